// ===== hw/rtl/lfc_pkg.sv =====
// Shared types, request codes and widths for the LRU frame cache with pin.
package lfc_pkg;

    // Fixed field widths
    localparam int INDEX_BITS = 16;
    localparam int REQ_W      = 3;
    localparam int OCC_W      = 5;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_SHOW  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_TOUCH = 3'd1;
    localparam logic [REQ_W-1:0] REQ_FILL  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_PROBE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_FLUSH = 3'd4;

    // Request beat
    typedef struct packed {
        logic [REQ_W-1:0]      req_type;
        logic [INDEX_BITS-1:0] frame_index;
    } lfc_in_t;

    // Result beat
    typedef struct packed {
        logic                  hit;
        logic                  evicted_valid;
        logic [INDEX_BITS-1:0] evicted_index;
        logic [OCC_W-1:0]      occupancy;
    } lfc_out_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_COMMIT
    } lfc_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic lookup;
        logic commit;
    } lfc_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;
    } lfc_stat_t;

endpackage

// ===== hw/rtl/lfc_datapath.sv =====
// Tag store, rank bookkeeping, pin register and result register of the frame cache.
module lfc_datapath #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lfc_pkg::lfc_in_t              req,
    input  lfc_pkg::lfc_cmd_t             cmd,
    output lfc_pkg::lfc_stat_t            stat,
    input  logic                          cfg_we,
    input  logic [lfc_pkg::OCC_W-1:0]     cfg_data,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output lfc_pkg::lfc_out_t             rsp
);
    import lfc_pkg::*;

    localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [OCC_W-1:0] MaxOcc   = OCC_W'(MAX_ENTRIES);
    localparam logic [OCC_W-1:0] CapReset = OCC_W'((MAX_ENTRIES < 16) ? MAX_ENTRIES : 16);
    localparam logic [OCC_W-1:0] OneOcc   = OCC_W'(1);
    localparam logic [OCC_W-1:0] TwoOcc   = OCC_W'(2);

    // Tag store and replacement state
    logic [INDEX_BITS-1:0] frame_reg [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_reg, valid_next;
    logic [RANK_W-1:0]     rank_reg  [MAX_ENTRIES];
    logic [RANK_W-1:0]     rank_next [MAX_ENTRIES];
    logic [INDEX_BITS-1:0] pin_frame_reg, pin_frame_next;
    logic                  pin_valid_reg, pin_valid_next;
    logic [OCC_W-1:0]      held_reg, held_next;
    logic [OCC_W-1:0]      cap_reg;

    // Request held for the duration of one item
    logic [REQ_W-1:0]      rq_type_reg;
    logic [INDEX_BITS-1:0] rq_frame_reg;

    // Lookup decisions
    logic                   hit_reg, hit_next;
    logic [MAX_ENTRIES-1:0] match_reg, match_next;
    logic [RANK_W-1:0]      match_rank_reg, match_rank_next;
    logic [MAX_ENTRIES-1:0] victim_reg, victim_next;
    logic [RANK_W-1:0]      victim_rank_reg, victim_rank_next;
    logic                   evict_reg, evict_next;
    logic                   self_evict_reg, self_evict_next;
    logic                   store_new_reg, store_new_next;
    logic [INDEX_BITS-1:0]  ev_index_reg, ev_index_next;

    // Result register
    logic     rsp_valid_reg;
    lfc_out_t rsp_reg, rsp_next;

    // Lookup helpers
    logic [MAX_ENTRIES-1:0] last_vec, prev_vec;
    logic [INDEX_BITS-1:0]  last_frame, victim_frame;
    logic                   is_fill, need_evict, last_pinned;

    // Commit helpers
    logic [MAX_ENTRIES-1:0] valid_after, free_vec;
    logic [OCC_W-1:0]       cap_next;

    // Match the tag in parallel and pick the victim by rank
    always_comb
    begin
        match_next      = '0;
        last_vec        = '0;
        prev_vec        = '0;
        match_rank_next = '0;
        last_frame      = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            match_next[i] = valid_reg[i] && (frame_reg[i] == rq_frame_reg);
            last_vec[i] = valid_reg[i] && (OCC_W'(rank_reg[i]) == (held_reg - OneOcc));
            prev_vec[i] = valid_reg[i] && (OCC_W'(rank_reg[i]) == (held_reg - TwoOcc));
            match_rank_next = match_rank_next | (match_next[i] ? rank_reg[i] : '0);
            last_frame      = last_frame | (last_vec[i] ? frame_reg[i] : '0);
        end
        hit_next    = |match_next;
        is_fill     = (rq_type_reg == REQ_FILL);
        need_evict  = is_fill && !hit_next && (held_reg >= cap_reg) && (held_reg != '0);
        last_pinned = (|last_vec) && pin_valid_reg && (last_frame == pin_frame_reg);
        self_evict_next = need_evict && last_pinned && (held_reg == OneOcc);
        if (!need_evict)
            victim_next = '0;
        else if (last_pinned)
            victim_next = (held_reg == OneOcc) ? '0 : prev_vec;
        else
            victim_next = last_vec;
        evict_next       = |victim_next;
        victim_frame     = '0;
        victim_rank_next = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            victim_frame     = victim_frame | (victim_next[i] ? frame_reg[i] : '0);
            victim_rank_next = victim_rank_next | (victim_next[i] ? rank_reg[i] : '0);
        end
        ev_index_next  = self_evict_next ? rq_frame_reg : victim_frame;
        store_new_next = is_fill && !hit_next && !self_evict_next;
    end

    // Lowest free slot once the victim is gone
    assign valid_after = valid_reg & ~victim_reg;
    assign free_vec    = ~valid_after & (valid_after + MAX_ENTRIES'(1));

    // Work out the store update for the request
    always_comb
    begin
        valid_next     = valid_reg;
        rank_next      = rank_reg;
        pin_frame_next = pin_frame_reg;
        pin_valid_next = pin_valid_reg;
        held_next      = held_reg;
        case (rq_type_reg)
            REQ_SHOW, REQ_TOUCH:
            begin
                if (rq_type_reg == REQ_SHOW)
                begin
                    pin_frame_next = rq_frame_reg;
                    pin_valid_next = 1'b1;
                end
                if (hit_reg)
                begin
                    for (int i = 0; i < MAX_ENTRIES; i++)
                    begin
                        if (match_reg[i])
                            rank_next[i] = '0;
                        else if (valid_reg[i] && (rank_reg[i] < match_rank_reg))
                            rank_next[i] = rank_reg[i] + RANK_W'(1);
                    end
                end
            end
            REQ_FILL:
            begin
                if (store_new_reg)
                begin
                    for (int i = 0; i < MAX_ENTRIES; i++)
                    begin
                        if (free_vec[i])
                        begin
                            valid_next[i] = 1'b1;
                            rank_next[i]  = '0;
                        end
                        else if (valid_after[i])
                        begin
                            // Closing the victim's gap and ageing by one cancel out
                            if (!(evict_reg && (rank_reg[i] > victim_rank_reg)))
                                rank_next[i] = rank_reg[i] + RANK_W'(1);
                        end
                        else
                        begin
                            valid_next[i] = 1'b0;
                        end
                    end
                    held_next = evict_reg ? held_reg : held_reg + OneOcc;
                end
            end
            REQ_FLUSH:
            begin
                valid_next     = '0;
                for (int i = 0; i < MAX_ENTRIES; i++)
                    rank_next[i] = '0;
                pin_frame_next = '0;
                pin_valid_next = 1'b0;
                held_next      = '0;
            end
            default:
            begin
                held_next = held_reg;
            end
        endcase
    end

    // Form the result beat
    always_comb
    begin
        rsp_next               = '0;
        rsp_next.hit           = hit_reg
                                 && (rq_type_reg inside {REQ_SHOW, REQ_TOUCH, REQ_FILL, REQ_PROBE});
        rsp_next.evicted_valid = evict_reg || self_evict_reg;
        rsp_next.evicted_index = ev_index_reg;
        rsp_next.occupancy     = held_next;
    end

    // Clamp a capacity write into range
    always_comb
    begin
        if (cfg_data == '0)
            cap_next = OneOcc;
        else if (cfg_data > MaxOcc)
            cap_next = MaxOcc;
        else
            cap_next = cfg_data;
    end

    // Control state: valid bits, ranks, pin, count, capacity, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++)
                rank_reg[i] <= '0;
            pin_frame_reg <= '0;
            pin_valid_reg <= 1'b0;
            held_reg      <= '0;
            cap_reg       <= CapReset;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                valid_reg     <= valid_next;
                rank_reg      <= rank_next;
                pin_frame_reg <= pin_frame_next;
                pin_valid_reg <= pin_valid_next;
                held_reg      <= held_next;
            end
            // Take capacity only with an empty store
            if (cfg_we && (held_reg == '0))
                cap_reg <= cap_next;
            if (cmd.commit)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Payload registers: request, lookup decisions, tags, result
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rq_type_reg  <= req.req_type;
            rq_frame_reg <= req.frame_index;
        end
        if (cmd.lookup)
        begin
            hit_reg         <= hit_next;
            match_reg       <= match_next;
            match_rank_reg  <= match_rank_next;
            victim_reg      <= victim_next;
            victim_rank_reg <= victim_rank_next;
            evict_reg       <= evict_next;
            self_evict_reg  <= self_evict_next;
            store_new_reg   <= store_new_next;
            ev_index_reg    <= ev_index_next;
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
            for (int i = 0; i < MAX_ENTRIES; i++)
                if (store_new_reg && (rq_type_reg == REQ_FILL) && free_vec[i])
                    frame_reg[i] <= rq_frame_reg;
        end
    end

    assign stat.out_free = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid     = rsp_valid_reg;
    assign rsp           = rsp_reg;

endmodule

// ===== hw/rtl/lfc_ctrl.sv =====
// Sequencing state machine of the frame cache: capture, lookup, commit.
module lfc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  lfc_pkg::lfc_stat_t  stat,
    output lfc_pkg::lfc_cmd_t   cmd
);
    import lfc_pkg::*;

    lfc_state_t state_reg, state_next;

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        case (state_reg)
            ST_IDLE:   state_next = req_valid ? ST_LOOK : ST_IDLE;
            ST_LOOK:   state_next = ST_COMMIT;
            ST_COMMIT: state_next = stat.out_free ? ST_IDLE : ST_COMMIT;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall   = 1'b0;
                cmd.capture = req_valid;
            end
            ST_LOOK:
            begin
                cmd.lookup = 1'b1;
            end
            ST_COMMIT:
            begin
                cmd.commit = stat.out_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== hw/rtl/lru_frame_cache_with_pin.sv =====
// Top level of the LRU frame cache with one pinned entry.
// Holds up to MAX_ENTRIES (1 to 16) frame numbers with least-recently-used
// replacement; a show request pins a frame so that a fill passes over it when
// choosing what to evict. A request is captured at the edge that accepts it,
// matched against every tag and given its victim by rank in the next cycle,
// and then committed to the store with its result registered once the result
// register is free; the input is open again only after the commit, so a new
// request is taken once the last has passed the capture, lookup and commit steps.
// The result register lets the next request be accepted while a result is
// still stalled; a further stalled result holds the commit step. Capacity is
// written through the configuration channel, takes effect only while the
// store is empty, and is clamped to 1..MAX_ENTRIES. No clearing pass is
// needed after reset.
module lru_frame_cache_with_pin #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  lfc_pkg::lfc_in_t          req,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output lfc_pkg::lfc_out_t         rsp,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [lfc_pkg::OCC_W-1:0] cfg_data
);
    import lfc_pkg::*;

    lfc_cmd_t  cmd;
    lfc_stat_t stat;

    // Configuration is always taken
    assign cfg_ready = 1'b1;

    lfc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    lfc_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // An accepted beat goes straight to lookup and blocks the input
    a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> cmd.lookup && req_stall)
        else $error("accepted request did not move to lookup");

    // Only one step of the sequence at a time
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.lookup, cmd.commit}))
        else $error("more than one command active");

    // Never overwrite a result that is still waiting
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(rsp_valid && rsp_stall))
        else $error("commit over a stalled result");

    // An eviction leaves at least one frame held
    a_evict_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.evicted_valid |-> rsp.occupancy != '0)
        else $error("eviction reported with empty store");

endmodule
